>>> design/pfla_pkg.sv
// Shared types and codes for the page free-list allocator.
// No dependencies.
package pfla_pkg;

  localparam int PageW   = 12;
  localparam int TableW  = 3;
  localparam int StatusW = 2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [StatusW-1:0] ST_OK   = 2'd0;
  localparam logic [StatusW-1:0] ST_FULL = 2'd1;
  localparam logic [StatusW-1:0] ST_BAD  = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_GROW = 5'b00100,
    S_POP  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

endpackage

>>> design/page_free_list_allocator.sv
// Page allocator over per-table linked free lists, next-page links in one RAM.
// Depends on pfla_pkg.
// Steps: a free or rejected request passes EXEC and OUT before its result beat;
// an allocate from a non-empty list passes EXEC, POP, OUT; one that grows
// the table runs GROW (one RAM write per new page), then EXEC, POP and OUT.
// One request in flight; the next beat is taken the cycle after the result is
// registered. Reset clears list heads to empty and counts to one; the link RAM is
// not cleared and needs no clearing pass.
module page_free_list_allocator
  import pfla_pkg::*;
#(
  parameter int TABLES     = 8,
  parameter int MAX_PAGES  = 4096,
  parameter int GROW_COUNT = 100
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_opcode,
  input  logic [TableW-1:0]  in_table_req,
  input  logic [PageW-1:0]   in_page,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [PageW-1:0]   out_alloc_page,
  output logic [StatusW-1:0] out_status
);

  localparam int TW   = (TABLES > 1) ? $clog2(TABLES) : 1;
  localparam int TIW  = (TW > TableW) ? TW : TableW;
  localparam int PW   = $clog2(MAX_PAGES);
  localparam int CW   = $clog2(MAX_PAGES + 1);
  localparam int CMPW = (CW > PageW) ? CW : PageW;
  localparam int SW   = $clog2(MAX_PAGES + GROW_COUNT + 1);
  localparam int GW   = $clog2(GROW_COUNT + 1);
  localparam int AW   = TW + PW;

  state_t               state_r, state_nxt;
  logic                 op_r;
  logic [TW-1:0]        tbl_r;
  logic                 tbl_ok_r;
  logic [PW-1:0]        page_r;
  logic                 page_ok_r;
  logic [PW-1:0]        grow_ptr_r, grow_ptr_nxt;
  logic [GW-1:0]        grow_left_r, grow_left_nxt;
  logic [PW-1:0]        res_page_r, res_page_nxt;
  logic [StatusW-1:0]   res_status_r, res_status_nxt;
  logic                 out_valid_r;
  logic [PW-1:0]        out_page_r;
  logic [StatusW-1:0]   out_status_r;

  logic [PW-1:0]        head_r  [TABLES];
  logic [CW-1:0]        count_r [TABLES];
  logic                 head_we, count_we;
  logic [PW-1:0]        head_wdata;
  logic [CW-1:0]        count_wdata;

  logic [PW-1:0]        next_mem [2**AW];
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [PW-1:0]        mem_wdata;
  logic [PW-1:0]        rd_data_r;

  logic                 in_beat;
  logic [PW-1:0]        cur_head;
  logic [CW-1:0]        cur_count;
  logic [SW-1:0]        grown_sum;
  logic                 grow_fits;
  logic [CMPW-1:0]      in_page_ext;
  logic [TIW-1:0]       in_tbl_ext;

  assign in_beat     = in_valid && !in_stall;
  assign in_stall    = (state_r != S_IDLE);
  assign in_page_ext = CMPW'(in_page);
  assign in_tbl_ext  = TIW'(in_table_req);

  assign cur_head  = head_r[tbl_r];
  assign cur_count = count_r[tbl_r];
  assign grown_sum = SW'(cur_count) + SW'(GROW_COUNT);
  assign grow_fits = (grown_sum <= SW'(MAX_PAGES));

  always_ff @(posedge clk) begin
    if (in_beat) begin
      op_r      <= in_opcode;
      tbl_r     <= in_tbl_ext[TW-1:0];
      tbl_ok_r  <= (32'(in_table_req) < TABLES);
      page_r    <= in_page_ext[PW-1:0];
      page_ok_r <= (in_page_ext < CMPW'(MAX_PAGES)) && (in_page != '0);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    grow_ptr_nxt   = grow_ptr_r;
    grow_left_nxt  = grow_left_r;
    res_page_nxt   = res_page_r;
    res_status_nxt = res_status_r;
    head_we        = 1'b0;
    head_wdata     = page_r;
    count_we       = 1'b0;
    count_wdata    = grown_sum[CW-1:0];
    mem_we         = 1'b0;
    mem_waddr      = {tbl_r, page_r};
    mem_wdata      = cur_head;
    unique case (state_r)
      S_IDLE: begin
        if (in_beat) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        res_page_nxt = '0;
        if (!tbl_ok_r) begin
          res_status_nxt = (op_r == OP_FREE) ? ST_BAD : ST_FULL;
          state_nxt      = S_OUT;
        end else if (op_r == OP_FREE) begin
          if (!page_ok_r || (CW'(page_r) >= cur_count)) begin
            res_status_nxt = ST_BAD;
          end else begin
            res_status_nxt = ST_OK;
            mem_we         = 1'b1;
            head_we        = 1'b1;
          end
          state_nxt = S_OUT;
        end else if (cur_head != '0) begin
          state_nxt = S_POP;
        end else if (!grow_fits) begin
          res_status_nxt = ST_FULL;
          state_nxt      = S_OUT;
        end else begin
          head_we       = 1'b1;
          head_wdata    = cur_count[PW-1:0];
          count_we      = 1'b1;
          grow_ptr_nxt  = cur_count[PW-1:0];
          grow_left_nxt = GW'(GROW_COUNT - 1);
          state_nxt     = S_GROW;
        end
      end
      S_GROW: begin
        mem_we        = 1'b1;
        mem_waddr     = {tbl_r, grow_ptr_r};
        mem_wdata     = (grow_left_r == '0) ? '0 : grow_ptr_r + PW'(1);
        grow_ptr_nxt  = grow_ptr_r + PW'(1);
        grow_left_nxt = grow_left_r - GW'(1);
        if (grow_left_r == '0) state_nxt = S_EXEC;
      end
      S_POP: begin
        res_page_nxt   = cur_head;
        res_status_nxt = ST_OK;
        head_we        = 1'b1;
        head_wdata     = rd_data_r;
        state_nxt      = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < TABLES; i++) begin
        head_r[i]  <= '0;
        count_r[i] <= CW'(1);
      end
    end else begin
      state_r <= state_nxt;
      if (head_we)  head_r[tbl_r]  <= head_wdata;
      if (count_we) count_r[tbl_r] <= count_wdata;
      if (state_r == S_OUT && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    grow_ptr_r   <= grow_ptr_nxt;
    grow_left_r  <= grow_left_nxt;
    res_page_r   <= res_page_nxt;
    res_status_r <= res_status_nxt;
    if (state_r == S_OUT && (!out_valid_r || !out_stall)) begin
      out_page_r   <= res_page_r;
      out_status_r <= res_status_r;
    end
  end

  // next-page link RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) next_mem[mem_waddr] <= mem_wdata;
    rd_data_r <= next_mem[{tbl_r, cur_head}];
  end

  logic [CMPW-1:0] out_page_ext;
  assign out_page_ext   = CMPW'(out_page_r);
  assign out_valid      = out_valid_r;
  assign out_alloc_page = out_page_ext[PageW-1:0];
  assign out_status     = out_status_r;

`ifndef SYNTHESIS
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> (state_r == S_EXEC))
    else $error("beat accepted outside idle");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_alloc_page == '0))
    else $error("failed request returned a page");

  a_grow_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GROW) |=> (state_r == S_GROW || state_r == S_EXEC))
    else $error("growth left early");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && !(out_valid && out_stall)) |=> out_valid)
    else $error("result beat lost");

  a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) |=> (res_status_r == ST_OK && res_page_r != '0))
    else $error("pop produced empty page");
`endif

endmodule
